// ----- hdl/bsmc_pkg.sv -----
package bsmc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RemW   = 24;
  localparam int unsigned DivW   = RemW + 1;
  // shift line holds the old remainder followed by the new byte
  localparam int unsigned ShW    = RemW + ByteW;
  localparam int unsigned CntW   = $clog2(ShW);

  localparam logic [DivW-1:0] DivReset = DivW'(255);
  localparam logic [DivW-1:0] DivMax   = DivW'(1) << RemW;
  localparam logic [DivW-1:0] DivMin   = DivW'(1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // zero acts as one, anything above 2^24 acts as 2^24
  function automatic logic [DivW-1:0] eff_divisor(input logic [DivW-1:0] raw);
    logic [DivW-1:0] d;
    d = raw;
    if (raw == '0) begin
      d = DivMin;
    end else if (raw > DivMax) begin
      d = DivMax;
    end
    return d;
  endfunction

endpackage

// ----- hdl/byte_stream_mod_checksum_core.sv -----
// Running remainder of a byte stream, read as one base-256 number, modulo a
// programmable divisor.
// Input channel: data_byte_i and block_end_i with in_valid_i / in_stall_o; a
// request is taken at a clock edge with valid high and stall low.
// Output channel: running_remainder_o and block_done_o with out_valid_o /
// out_stall_i, one result per input request, block_done_o echoes block_end_i.
// Configuration: cfg_we_i writes cfg_wdata_i into the divisor; only write
// while no request is in flight.
// Operation: the reduction shifts one bit per cycle through a compare and
// conditional subtract; the last bit waits while a stalled result is still held.
// The result is loaded into the output register on the edge that folds the last
// bit, and the next request is taken on that same edge. After a divisor write
// the first byte also folds the 24 stored remainder bits.
// Reset clears the remainder to zero and sets the divisor to 255.
// A stalled result stays in the output register; the block finishes the
// following byte up to its last bit and waits there until the result is taken.
module byte_stream_mod_checksum_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsmc_pkg::DivW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bsmc_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         block_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bsmc_pkg::RemW-1:0]    running_remainder_o,
  output logic                         block_done_o
);

  localparam int unsigned RemW  = bsmc_pkg::RemW;
  localparam int unsigned DivW  = bsmc_pkg::DivW;
  localparam int unsigned ShW   = bsmc_pkg::ShW;
  localparam int unsigned CntW  = bsmc_pkg::CntW;
  localparam int unsigned ByteW = bsmc_pkg::ByteW;

  bsmc_pkg::state_e state_q, state_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             red_q, red_d;
  logic [RemW-1:0]  r_q, r_d;
  logic [ShW-1:0]   sh_q, sh_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [RemW-1:0]  out_rem_q, out_rem_d;
  logic             out_done_q, out_done_d;

  logic [DivW-1:0]  trial;
  logic [DivW-1:0]  diff;
  logic [RemW-1:0]  r_step;
  logic             last_bit;
  logic             finish;
  logic             accept;
  logic [RemW-1:0]  src_rem;
  logic             src_red;

  always_comb begin
    // r stays below the divisor, so the trial value fits 25 bits
    trial  = {r_q, sh_q[ShW-1]};
    diff   = trial - div_q;
    r_step = (trial >= div_q) ? diff[RemW-1:0] : trial[RemW-1:0];

    last_bit   = (state_q == bsmc_pkg::ST_RUN) && (cnt_q == '0);
    finish     = last_bit && (!out_valid_q || !out_stall_i);
    in_stall_o = !((state_q == bsmc_pkg::ST_IDLE) || finish);
    accept     = in_valid_i && !in_stall_o;

    src_rem = finish ? r_step : rem_q;
    src_red = finish || red_q;

    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    red_d       = red_q;
    r_d         = r_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_rem_d   = out_rem_q;
    out_done_d  = out_done_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bsmc_pkg::ST_RUN: begin
        if (cnt_q != '0) begin
          r_d   = r_step;
          sh_d  = {sh_q[ShW-2:0], 1'b0};
          cnt_d = cnt_q - CntW'(1);
        end else if (finish) begin
          rem_d       = r_step;
          red_d       = 1'b1;
          out_valid_d = 1'b1;
          out_rem_d   = r_step;
          out_done_d  = last_q;
          state_d     = bsmc_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (accept) begin
      last_d  = block_end_i;
      state_d = bsmc_pkg::ST_RUN;
      if (src_red) begin
        // remainder already below the divisor: only the byte bits remain
        r_d   = src_rem;
        sh_d  = {data_byte_i, RemW'(0)};
        cnt_d = CntW'(ByteW - 1);
      end else begin
        // fold the stored remainder bits too, starting from zero
        r_d   = '0;
        sh_d  = {src_rem, data_byte_i};
        cnt_d = CntW'(ShW - 1);
      end
    end

    if (cfg_we_i) begin
      div_d = bsmc_pkg::eff_divisor(cfg_wdata_i);
      red_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsmc_pkg::ST_IDLE;
      div_q       <= bsmc_pkg::DivReset;
      rem_q       <= '0;
      red_q       <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_q       <= div_d;
      rem_q       <= rem_d;
      red_q       <= red_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    sh_q       <= sh_d;
    last_q     <= last_d;
    out_rem_q  <= out_rem_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o         = out_valid_q;
  assign running_remainder_o = out_rem_q;
  assign block_done_o        = out_done_q;

  a_partial_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsmc_pkg::ST_RUN) |-> ({1'b0, r_q} < div_q))
    else $error("partial remainder not below divisor");

  a_stored_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q |-> ({1'b0, rem_q} < div_q))
    else $error("stored remainder marked reduced but not below divisor");

  a_accept_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == bsmc_pkg::ST_RUN))
    else $error("accepted request did not start the reduction");

  a_finish_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && (out_rem_q == rem_q)))
    else $error("finished result not presented at the output");

endmodule
